// ----- sv/vpfit_pkg.sv -----
// Package: shared widths, opcodes and divider request and response types for the viewport block.
package vpfit_pkg;
  localparam int DimBits   = 12;
  localparam int FracBits  = 16;
  localparam int RatioBits = DimBits + FracBits;
  localparam int DivBits   = 32;
  localparam int CntBits   = 6;

  localparam logic [2:0] RegSrcW   = 3'd0;
  localparam logic [2:0] RegSrcH   = 3'd1;
  localparam logic [2:0] RegScrW   = 3'd2;
  localparam logic [2:0] RegScrH   = 3'd3;
  localparam logic [2:0] RegInset  = 3'd4;
  localparam logic [2:0] RegFourTh = 3'd5;
  localparam logic [2:0] RegMode   = 3'd6;

  localparam logic [2:0] ModeNative  = 3'd0;
  localparam logic [2:0] ModeFit     = 3'd1;
  localparam logic [2:0] ModeFit8    = 3'd2;
  localparam logic [2:0] ModeInteger = 3'd3;
  localparam logic [2:0] ModeStretch = 3'd4;

  typedef struct packed {
    logic               go;
    logic [DivBits-1:0] num;
    logic [DivBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivBits-1:0] quo;
  } div_rsp_t;
endpackage

// ----- sv/vpfit_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module vpfit_div
  import vpfit_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [DivBits-1:0] quo;
  logic [DivBits:0]   rem;
  logic [DivBits-1:0] den;
  logic [CntBits-1:0] cnt;
  logic               run;
  logic               done_r;
  logic [DivBits:0]   trial;

  assign trial = {rem[DivBits-1:0], quo[DivBits-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        quo <= req.num;
        den <= req.den;
        rem <= '0;
        cnt <= CntBits'(DivBits - 1);
      end else if (run) begin
        if (!trial[DivBits]) begin
          rem <= trial;
          quo <= {quo[DivBits-2:0], 1'b1};
        end else begin
          rem <= {rem[DivBits-1:0], quo[DivBits-1]};
          quo <= {quo[DivBits-2:0], 1'b0};
        end
        if (cnt == '0) begin
          run <= 1'b0;
          done_r <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end
  assign rsp = '{done_r, quo};

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done_r |-> !run)
    else $error("divider done while running");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done_r |=> !done_r)
    else $error("divider done longer than one cycle");
  a_go_idle: assert property (@(posedge clk) disable iff (rst) req.go |-> !run)
    else $error("divide issued while running");
endmodule

// ----- sv/viewport_fit_and_point_map_top.sv -----
// Top level: config registers, sequencer and stored window around one shared divider.
//
// A request is taken when start is high and busy is low. Divides run one at a
// time on the shared 32-step divider. A recompute that reaches the divider
// takes one to four divides; a point map that passes its checks takes two.
// busy stays high for the whole request, and the result appears with
// done high for exactly one cycle; the receiver cannot stall it, so capture
// it then. Config writes go through wr_en/wr_index/wr_data and must only
// happen while busy is low.
module viewport_fit_and_point_map_top
  import vpfit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [2:0]           wr_index,
  input  logic [DimBits-1:0]   wr_data,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action,
  input  logic [DimBits-1:0]   point_x,
  input  logic [DimBits-1:0]   point_y,
  output logic                 done,
  output logic                 status,
  output logic [DimBits-1:0]   view_x,
  output logic [DimBits-1:0]   view_y,
  output logic [DimBits-1:0]   view_width,
  output logic [DimBits-1:0]   view_height,
  output logic [RatioBits-1:0] ratio_x,
  output logic [RatioBits-1:0] ratio_y,
  output logic [DimBits-1:0]   mapped_x,
  output logic [DimBits-1:0]   mapped_y
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_D1, S_W1, S_D2, S_W2, S_D3, S_W3, S_D4, S_W4, S_FIN,
    S_MAP1, S_MW1, S_MAP2, S_MW2
  } state_t;

  state_t state;
  logic [DimBits-1:0] src_w, src_h, scr_w, scr_h, inset_r;
  logic               four_th;
  logic [2:0]         mode;
  logic [DimBits-1:0] win_x, win_y, win_w, win_h;
  logic [RatioBits-1:0] win_rx, win_ry;
  logic               win_valid;
  logic [DimBits-1:0] px, py, inset, ah, rw, rh, w, h, s;
  logic               ok;
  div_req_t dreq;
  div_rsp_t drsp;

  vpfit_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Hold the config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= 12'd640; src_h <= 12'd400; scr_w <= 12'd640; scr_h <= 12'd400;
      inset_r <= '0; four_th <= 1'b0; mode <= ModeFit;
    end else if (wr_en) begin
      unique case (wr_index)
        RegSrcW:   src_w <= wr_data;
        RegSrcH:   src_h <= wr_data;
        RegScrW:   scr_w <= wr_data;
        RegScrH:   scr_h <= wr_data;
        RegInset:  inset_r <= wr_data;
        RegFourTh: four_th <= wr_data[0];
        RegMode:   mode <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  // Quotient clipped to dimension width (values always fit where used).
  logic [DimBits-1:0] q12;
  logic [DivBits-1:0] qd;
  assign qd  = drsp.quo;
  assign q12 = qd[DimBits-1:0];
  logic qbig;
  assign qbig = |qd[DivBits-1:DimBits];

  logic [DimBits-1:0] w8;
  assign w8 = {w[DimBits-1:3], 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; done <= 1'b0; dreq.go <= 1'b0;
      win_valid <= 1'b0; win_x <= '0; win_y <= '0; win_w <= '0; win_h <= '0;
      win_rx <= '0; win_ry <= '0;
    end else begin
      done <= 1'b0;
      dreq.go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1; px <= point_x; py <= point_y;
            mapped_x <= '0; mapped_y <= '0;
            if (action) begin
              ok <= win_valid && src_w != 0 && src_h != 0 && win_w != 0 &&
                    win_h != 0 && point_x >= win_x && point_y >= win_y &&
                    {1'b0, point_x} < {1'b0, win_x} + {1'b0, win_w} &&
                    {1'b0, point_y} < {1'b0, win_y} + {1'b0, win_h};
              state <= S_MAP1;
            end else begin
              // Drop the stored window, then recompute.
              win_valid <= 1'b0; win_x <= '0; win_y <= '0; win_w <= '0;
              win_h <= '0; win_rx <= '0; win_ry <= '0;
              inset <= (inset_r < scr_h) ? inset_r : scr_h;
              rw <= four_th ? 12'd4 : src_w;
              rh <= four_th ? 12'd3 : src_h;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          ah <= scr_h - inset;
          if (src_w == 0 || src_h == 0 || scr_w == 0 || scr_h == 0 ||
              mode > ModeStretch || scr_h == inset) begin
            ok <= 1'b0; state <= S_FIN;
          end else if (mode == ModeStretch) begin
            w <= scr_w; h <= scr_h - inset; state <= S_D4;
          end else begin
            state <= S_D1;
          end
        end
        S_D1: begin
          // native: h=min(src_h,ah) then w=h*rw/rh; fit: w=ah*rw/rh; int: aw/src_w
          dreq.go <= 1'b1;
          if (mode == ModeNative) begin
            h <= (src_h < ah) ? src_h : ah;
            dreq.num <= DivBits'((src_h < ah) ? src_h : ah) * DivBits'(rw);
            dreq.den <= DivBits'(rh);
          end else if (mode == ModeInteger) begin
            dreq.num <= DivBits'(scr_w); dreq.den <= DivBits'(src_w);
          end else begin
            dreq.num <= DivBits'(ah) * DivBits'(rw); dreq.den <= DivBits'(rh);
          end
          state <= S_W1;
        end
        S_W1: if (drsp.done) begin
          if (mode == ModeInteger) begin
            s <= q12; state <= S_D2;
          end else if (mode == ModeNative) begin
            if (qbig || q12 > scr_w) begin
              w <= scr_w; state <= S_D2;
            end else begin
              w <= q12; state <= S_D4;
            end
          end else begin
            w <= (qbig || q12 > scr_w) ? scr_w : q12; state <= S_D2;
          end
        end
        S_D2: begin
          if (mode == ModeInteger) begin
            dreq.go <= 1'b1; dreq.num <= DivBits'(ah); dreq.den <= DivBits'(src_h);
            state <= S_W2;
          end else begin
            if (mode == ModeFit8) w <= w8;
            if ((mode == ModeFit8 ? w8 : w) == 0) begin
              ok <= 1'b0; state <= S_FIN;
            end else begin
              dreq.go <= 1'b1;
              dreq.num <= DivBits'(mode == ModeFit8 ? w8 : w) * DivBits'(rh);
              dreq.den <= DivBits'(rw);
              state <= S_W2;
            end
          end
        end
        S_W2: if (drsp.done) begin
          if (mode == ModeInteger) begin
            s <= (q12 < s) ? ((q12 == 0) ? 12'd1 : q12) : ((s == 0) ? 12'd1 : s);
            state <= S_D3;
          end else begin
            h <= q12; state <= S_D4;
          end
        end
        S_D3: begin
          // Integer multiple; clamp to the free area.
          w <= ((24'(src_w) * 24'(s)) > 24'(scr_w)) ? scr_w :
               DimBits'(24'(src_w) * 24'(s));
          h <= ((24'(src_h) * 24'(s)) > 24'(ah)) ? ah : DimBits'(24'(src_h) * 24'(s));
          state <= S_D4;
        end
        S_D4: begin
          if (w == 0 || h == 0) begin
            ok <= 1'b0; state <= S_FIN;
          end else begin
            dreq.go <= 1'b1;
            dreq.num <= DivBits'({w, {FracBits{1'b0}}}); dreq.den <= DivBits'(src_w);
            state <= S_W3;
          end
        end
        S_W3: if (drsp.done) begin
          win_rx <= qd[RatioBits-1:0];
          dreq.go <= 1'b1;
          dreq.num <= DivBits'({h, {FracBits{1'b0}}}); dreq.den <= DivBits'(src_h);
          state <= S_W4;
        end
        S_W4: if (drsp.done) begin
          win_ry <= qd[RatioBits-1:0];
          win_x <= (scr_w - w) >> 1;
          win_y <= inset + ((ah - h) >> 1);
          win_w <= w; win_h <= h; win_valid <= 1'b1;
          ok <= 1'b1; state <= S_FIN;
        end
        S_MAP1: begin
          if (!ok) begin
            state <= S_FIN;
          end else begin
            dreq.go <= 1'b1;
            dreq.num <= DivBits'(px - win_x) * DivBits'(src_w);
            dreq.den <= DivBits'(win_w);
            state <= S_MW1;
          end
        end
        S_MW1: if (drsp.done) begin
          mapped_x <= q12; state <= S_MAP2;
        end
        S_MAP2: begin
          dreq.go <= 1'b1;
          dreq.num <= DivBits'(py - win_y) * DivBits'(src_h);
          dreq.den <= DivBits'(win_h);
          state <= S_MW2;
        end
        S_MW2: if (drsp.done) begin
          mapped_y <= q12; state <= S_FIN;
        end
        S_FIN: begin
          status <= !ok; done <= 1'b1; busy <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign view_x = win_x;
  assign view_y = win_y;
  assign view_width = win_w;
  assign view_height = win_h;
  assign ratio_x = win_rx;
  assign ratio_y = win_ry;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    win_valid || (win_w == 0 && win_h == 0))
    else $error("stale window");
  a_no_idle_go: assert property (@(posedge clk) disable iff (rst)
    !(dreq.go && state == S_IDLE))
    else $error("divide from idle");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy)
    else $error("busy while idle");
endmodule

// ----- sim/testbench.sv -----
// Testbench for the viewport fit and point map block: directed table, then random requests.
module testbench
  import vpfit_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 4000;
  localparam int RandRequests = 1700;

  typedef enum logic {ActRecompute = 1'b0, ActMap = 1'b1} act_t;

  typedef struct packed {
    logic                 status;
    logic [DimBits-1:0]   vx;
    logic [DimBits-1:0]   vy;
    logic [DimBits-1:0]   vw;
    logic [DimBits-1:0]   vh;
    logic [RatioBits-1:0] rx;
    logic [RatioBits-1:0] ry;
    logic [DimBits-1:0]   mx;
    logic [DimBits-1:0]   my;
  } view_res_t;

  // One directed row: optional full config, then one request, optional typed result.
  typedef struct {
    bit                 set_cfg;
    logic [DimBits-1:0] cfg [7];
    act_t               act;
    logic [DimBits-1:0] px;
    logic [DimBits-1:0] py;
    bit                 has_exp;
    view_res_t          exp_res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [DimBits-1:0] wr_data = '0;
  logic start = 1'b0;
  logic busy;
  logic action = 1'b0;
  logic [DimBits-1:0] point_x = '0;
  logic [DimBits-1:0] point_y = '0;
  logic done;
  logic status;
  logic [DimBits-1:0] view_x, view_y, view_width, view_height, mapped_x, mapped_y;
  logic [RatioBits-1:0] ratio_x, ratio_y;

  viewport_fit_and_point_map_top u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of config and stored window.
  logic [DimBits-1:0] m_srcw, m_srch, m_scrw, m_scrh, m_inset;
  logic m_four3;
  logic [2:0] m_mode;
  logic [DimBits-1:0] w_x, w_y, w_w, w_h;
  logic [RatioBits-1:0] w_rx, w_ry;
  logic w_valid;

  view_res_t view_queue[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic void clear_window();
    w_x = '0; w_y = '0; w_w = '0; w_h = '0; w_rx = '0; w_ry = '0; w_valid = 1'b0;
  endfunction

  function automatic bit fit_window();
    longint unsigned inset, aw, ah, rw, rh, w, h, s, sx, sy;
    clear_window();
    if (m_srcw == 0 || m_srch == 0 || m_scrw == 0 || m_scrh == 0 || m_mode > ModeStretch)
      return 0;
    inset = (m_inset < m_scrh) ? m_inset : m_scrh;
    aw = m_scrw;
    ah = m_scrh - inset;
    if (ah == 0) return 0;
    rw = m_four3 ? 4 : m_srcw;
    rh = m_four3 ? 3 : m_srch;
    case (m_mode)
      ModeNative: begin
        h = (m_srch < ah) ? m_srch : ah;
        w = (h * rw) / rh;
        if (w > aw) begin
          w = aw;
          h = (w * rh) / rw;
        end
      end
      ModeFit, ModeFit8: begin
        w = (ah * rw) / rh;
        if (w > aw) w = aw;
        if (m_mode == ModeFit8) w = w & ~64'd7;
        if (w == 0) return 0;
        h = (w * rh) / rw;
      end
      ModeInteger: begin
        sx = aw / m_srcw;
        sy = ah / m_srch;
        s = (sx < sy) ? sx : sy;
        if (s < 1) s = 1;
        w = m_srcw * s;
        if (w > aw) w = aw;
        h = m_srch * s;
        if (h > ah) h = ah;
      end
      default: begin
        w = aw;
        h = ah;
      end
    endcase
    if (w == 0 || h == 0) return 0;
    w_x = DimBits'((aw - w) / 2);
    w_y = DimBits'(inset + (ah - h) / 2);
    w_w = DimBits'(w);
    w_h = DimBits'(h);
    w_rx = RatioBits'((w << FracBits) / m_srcw);
    w_ry = RatioBits'((h << FracBits) / m_srch);
    w_valid = 1'b1;
    return 1;
  endfunction

  function automatic view_res_t predict_view(act_t act, logic [DimBits-1:0] px,
                                             logic [DimBits-1:0] py);
    view_res_t r;
    bit ok;
    longint unsigned dx, dy;
    r = '0;
    if (act == ActRecompute) begin
      ok = fit_window();
    end else begin
      dx = px; dy = py;
      ok = w_valid && m_srcw != 0 && m_srch != 0 && w_w != 0 && w_h != 0 &&
           dx >= w_x && dy >= w_y && dx < w_x + w_w && dy < w_y + w_h;
      if (ok) begin
        r.mx = DimBits'(((dx - w_x) * m_srcw) / w_w);
        r.my = DimBits'(((dy - w_y) * m_srch) / w_h);
      end
    end
    r.status = !ok;
    r.vx = w_x; r.vy = w_y; r.vw = w_w; r.vh = w_h; r.rx = w_rx; r.ry = w_ry;
    return r;
  endfunction

  function automatic void store_reg(logic [2:0] idx, logic [DimBits-1:0] val);
    case (idx)
      RegSrcW:   m_srcw = val;
      RegSrcH:   m_srch = val;
      RegScrW:   m_scrw = val;
      RegScrH:   m_scrh = val;
      RegInset:  m_inset = val;
      RegFourTh: m_four3 = val[0];
      RegMode:   m_mode = val[2:0];
      default: ;
    endcase
  endfunction

  // Check every done pulse against the oldest expectation.
  always @(posedge clk) begin
    view_res_t got, want;
    if (!rst && done) begin
      got = '{status, view_x, view_y, view_width, view_height, ratio_x, ratio_y,
              mapped_x, mapped_y};
      if (view_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = view_queue.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %h got %h", $time, want.status, got.status); errors++;
        end
        if (got.vx !== want.vx) begin
          $display("%0t: view_x exp %0d got %0d", $time, want.vx, got.vx); errors++;
        end
        if (got.vy !== want.vy) begin
          $display("%0t: view_y exp %0d got %0d", $time, want.vy, got.vy); errors++;
        end
        if (got.vw !== want.vw) begin
          $display("%0t: view_width exp %0d got %0d", $time, want.vw, got.vw); errors++;
        end
        if (got.vh !== want.vh) begin
          $display("%0t: view_height exp %0d got %0d", $time, want.vh, got.vh); errors++;
        end
        if (got.rx !== want.rx) begin
          $display("%0t: ratio_x exp %h got %h", $time, want.rx, got.rx); errors++;
        end
        if (got.ry !== want.ry) begin
          $display("%0t: ratio_y exp %h got %h", $time, want.ry, got.ry); errors++;
        end
        if (got.mx !== want.mx) begin
          $display("%0t: mapped_x exp %0d got %0d", $time, want.mx, got.mx); errors++;
        end
        if (got.my !== want.my) begin
          $display("%0t: mapped_y exp %0d got %0d", $time, want.my, got.my); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no request and no result moves.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Write one register; the block must be idle here. The caller drops wr_en.
  task automatic write_reg(logic [2:0] idx, logic [DimBits-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    store_reg(idx, val);
    @(posedge clk);
  endtask

  // Drain outstanding results, then let the block settle before config writes.
  task automatic wait_drained();
    while (view_queue.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_all(logic [DimBits-1:0] cfg [7]);
    wait_drained();
    for (int i = 0; i < 7; i++) write_reg(3'(i), cfg[i]);
    wr_en <= 1'b0;
  endtask

  // Issue one request; hold start until the handshake edge, then drop it for a cycle.
  task automatic send_request(act_t act, logic [DimBits-1:0] px, logic [DimBits-1:0] py,
                              bit has_exp, view_res_t exp_res);
    view_res_t pred;
    start <= 1'b1;
    action <= act;
    point_x <= px;
    point_y <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_view(act, px, py);
    if (has_exp && pred !== exp_res) begin
      $display("%0t: table row disagrees with predictor exp %h pred %h", $time, exp_res, pred);
      errors++;
    end
    view_queue.push_back(has_exp ? exp_res : pred);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DimBits-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return DimBits'($urandom_range(1, 16));
      default: return DimBits'($urandom_range(1, 4095));
    endcase
  endfunction

  // Random point: mostly inside the window, sometimes just past its end or anywhere.
  function automatic logic [DimBits-1:0] rand_coord(logic [DimBits-1:0] lo,
                                                    logic [DimBits-1:0] len);
    int unsigned hi;
    if (len == 0 || $urandom_range(0, 4) == 0) return DimBits'($urandom());
    hi = lo + len;
    if ($urandom_range(0, 7) == 0) return DimBits'(hi);
    if ($urandom_range(0, 7) == 0) return lo;
    return DimBits'($urandom_range(lo, (hi > 4096) ? 4095 : hi - 1));
  endfunction

  dir_row_t dir_rows[$];
  logic [DimBits-1:0] cfg_rst [7] = '{640, 400, 640, 400, 0, 0, 1};
  logic [DimBits-1:0] cfg_a [7];

  task automatic add_row(bit set_cfg, logic [DimBits-1:0] c [7], act_t act,
                         logic [DimBits-1:0] px, logic [DimBits-1:0] py,
                         bit has_exp, view_res_t e);
    dir_row_t r;
    r.set_cfg = set_cfg; r.cfg = c; r.act = act; r.px = px; r.py = py;
    r.has_exp = has_exp; r.exp_res = e;
    dir_rows.push_back(r);
  endtask

  initial begin
    view_res_t full, fail_res;
    int burst;
    fail_res = '0;
    fail_res.status = 1'b1;
    full = '{1'b0, 12'd0, 12'd0, 12'd640, 12'd400, 28'h10000, 28'h10000, 12'd0, 12'd0};

    m_srcw = 640; m_srch = 400; m_scrw = 640; m_scrh = 400;
    m_inset = 0; m_four3 = 0; m_mode = ModeFit;
    clear_window();

    // Directed table. Map before any recompute fails with an empty window.
    add_row(0, cfg_rst, ActMap, 0, 0, 1, fail_res);
    add_row(0, cfg_rst, ActRecompute, 0, 0, 1, full);
    full.mx = 639; full.my = 399;
    add_row(0, cfg_rst, ActMap, 639, 399, 1, full);
    full.mx = 0; full.my = 0; full.status = 1'b1;
    add_row(0, cfg_rst, ActMap, 640, 0, 1, full);
    add_row(0, cfg_rst, ActMap, 4095, 4095, 1, full);
    // Modes 0..7, 4:3 on, with an inset.
    for (int m = 0; m < 8; m++) begin
      cfg_a = '{320, 200, 1024, 768, 20, 1, 12'(m)};
      add_row(1, cfg_a, ActRecompute, 0, 0, m > 4, fail_res);
      add_row(0, cfg_a, ActMap, 500, 400, 0, fail_res);
    end
    // Zero sizes, inset that fills the screen, fit8 collapsing to empty, then integer and stretch at the limits.
    cfg_a = '{0, 200, 640, 480, 0, 0, 1};
    add_row(1, cfg_a, ActRecompute, 0, 0, 1, fail_res);
    add_row(0, cfg_a, ActMap, 0, 0, 1, fail_res);
    cfg_a = '{320, 200, 640, 480, 4095, 0, 1};
    add_row(1, cfg_a, ActRecompute, 0, 0, 1, fail_res);
    cfg_a = '{4095, 1, 7, 4095, 0, 0, 2};
    add_row(1, cfg_a, ActRecompute, 0, 0, 1, fail_res);
    cfg_a = '{4095, 4095, 4095, 4095, 0, 0, 3};
    add_row(1, cfg_a, ActRecompute, 0, 0, 0, fail_res);
    add_row(0, cfg_a, ActMap, 4094, 4094, 0, fail_res);
    cfg_a = '{1, 1, 4095, 4095, 4094, 0, 4};
    add_row(1, cfg_a, ActRecompute, 0, 0, 0, fail_res);
    add_row(0, cfg_a, ActMap, 4095, 4094, 0, fail_res);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) write_all(dir_rows[i].cfg);
      send_request(dir_rows[i].act, dir_rows[i].px, dir_rows[i].py,
                   dir_rows[i].has_exp, dir_rows[i].exp_res);
    end

    // Random phases: new config, a recompute, then a burst of maps and stray recomputes.
    for (int n = 0; n < RandRequests;) begin
      wait_drained();
      for (int i = 0; i < 7; i++)
        if (i == 0 || $urandom_range(0, 2) != 0)
          cfg_a[i] = (i == 5) ? DimBits'($urandom_range(0, 1)) :
                     (i == 6) ? DimBits'(($urandom_range(0, 9) == 0) ?
                                          $urandom_range(5, 7) : $urandom_range(0, 4)) :
                     (i == 4) ? (($urandom_range(0, 2) == 0) ? rand_dim() :
                                 DimBits'($urandom_range(0, 64))) :
                     rand_dim();
        else
          cfg_a[i] = (i == 0) ? m_srcw : (i == 1) ? m_srch : (i == 2) ? m_scrw :
                     (i == 3) ? m_scrh : (i == 4) ? m_inset : (i == 5) ? 12'(m_four3) :
                     12'(m_mode);
      for (int i = 0; i < 7; i++) write_reg(3'(i), cfg_a[i]);
      wr_en <= 1'b0;
      send_request(ActRecompute, DimBits'($urandom()), DimBits'($urandom()), 0, fail_res);
      n++;
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++, n++) begin
        // Sometimes a gap between requests; more often none at all.
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 80)) @(posedge clk);
        if ($urandom_range(0, 19) == 0)
          send_request(ActRecompute, DimBits'($urandom()), DimBits'($urandom()), 0, fail_res);
        else
          send_request(ActMap, rand_coord(w_x, w_w), rand_coord(w_y, w_h), 0, fail_res);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && view_queue.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
